/* sv/bttp_pkg.sv */
// Package for the bilateral tension teleoperation core.
// It holds the widths, register indexes, controller states and saturation helpers.
// It has no dependencies.
package bttp_pkg;

    localparam int MOTOR_COUNT = 4;
    localparam int GAIN_W      = 24;
    localparam int VAL_W       = 32;
    localparam int SUM_W       = 48;
    localparam int MUL_XW      = 48;
    localparam int ACC_W       = 64;
    localparam int FRAC_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP,
        REG_INTEG,
        REG_DERIV,
        REG_FOLLOW,
        REG_RATIO,
        REG_MARGIN,
        REG_DIR,
        REG_WARMUP
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_ERR,
        ST_MUL,
        ST_POST,
        ST_CMD,
        ST_SAT,
        ST_DONE
    } ctl_state_t;

    typedef enum logic [2:0] {
        TERM_TGT,
        TERM_P,
        TERM_D,
        TERM_I,
        TERM_FOLLOW
    } term_t;

    function automatic logic signed [SUM_W-1:0] sat48(input logic signed [SUM_W:0] v);
        logic signed [SUM_W-1:0] r;
        if (v[SUM_W] != v[SUM_W-1]) begin
            r = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else begin
            r = v[SUM_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > SUM_W'(signed'({1'b0, {(VAL_W-1){1'b1}}}))) begin
            r = {1'b0, {(VAL_W-1){1'b1}}};
        end
        else if (v < -(SUM_W'(signed'({1'b0, 1'b1, {(VAL_W-1){1'b0}}})))) begin
            r = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

/* sv/bttp_mul.sv */
// Bit-serial signed multiplier, one gain bit per cycle.
// Depends on bttp_pkg for default widths.
// Used by the top level for every gain product.
module bttp_mul import bttp_pkg::*; #(
    parameter int GW = GAIN_W,
    parameter int XW = MUL_XW
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [GW-1:0]     gain,
    input  logic signed [XW-1:0]     operand,
    output logic                     done,
    output logic signed [XW+GW:0]    product
);

    localparam int CNT_W = $clog2(GW + 1);

    logic signed [XW:0]   hi_reg, hi_next;
    logic [GW-1:0]        lo_reg, lo_next;
    logic signed [XW-1:0] x_reg, x_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic signed [XW:0]   addend;
    logic signed [XW:0]   sum;
    logic                 last;

    always_comb
    begin
        last   = (cnt_reg == CNT_W'(GW - 1));
        addend = '0;
        if (lo_reg[0]) begin
            addend = last ? -{x_reg[XW-1], x_reg} : {x_reg[XW-1], x_reg};
        end
        sum       = hi_reg + addend;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        x_next    = x_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            hi_next   = '0;
            lo_next   = gain;
            x_next    = operand;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg) begin
            hi_next  = {sum[XW], sum[XW:1]};
            lo_next  = {sum[0], lo_reg[GW-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (last) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        x_reg  <= x_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

/* sv/bilateral_tension_pid_teleop_core.sv */
// Top level of the bilateral tension teleoperation controller.
// Depends on bttp_pkg and on the serial multiplier bttp_mul.
//
//  Channel | Signals                                  | Word
//  s       | s_tvalid s_tready s_tdata[255:0] s_tuser | positions, tensions, fresh flags
//  m       | m_tvalid m_tready m_tdata[127:0] m_tuser | four commands, phase
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data   | one register write
//
// A tick that emits nothing is taken while idle and the block stays idle.
// Each product waits on the bit-serial multiplier, which computes up to twelve
// products in turn for each word: three per setup motor, four per bilateral master
// and one per bilateral slave. The next tick is taken only once the word is in the
// output register and the block is back in idle. Reset clears control state, samples,
// sums and flags and sets config registers to defaults, not origins, commands, working
// values or the output word. A waiting output word holds back the next word.
module bilateral_tension_pid_teleop_core import bttp_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // pos_master_a, pos_slave_a, pos_master_b, pos_slave_b,
    // ten_master_a, ten_slave_a, ten_master_b, ten_slave_b
    input  logic [8*VAL_W-1:0]        s_tdata,
    // pos_fresh, ten_fresh
    input  logic [1:0]                s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // cmd_master_a, cmd_slave_a, cmd_master_b, cmd_slave_b
    output logic [4*VAL_W-1:0]        m_tdata,
    // phase
    output logic                      m_tuser,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    localparam int PROD_W = MUL_XW + GAIN_W + 1;

    logic signed [GAIN_W-1:0] kp_reg, ki_reg, kd_reg, fg_reg, fr_reg;
    logic signed [VAL_W-1:0]  margin_reg;
    logic [MOTOR_COUNT-1:0]   dir_reg;
    logic [7:0]               warm_reg;

    logic signed [VAL_W-1:0] pos_reg [MOTOR_COUNT];
    logic signed [VAL_W-1:0] pos_next [MOTOR_COUNT];
    logic signed [VAL_W-1:0] origin_reg [MOTOR_COUNT];
    logic signed [VAL_W-1:0] origin_next [MOTOR_COUNT];
    logic signed [VAL_W-1:0] ten_reg [MOTOR_COUNT];
    logic signed [VAL_W-1:0] ten_next [MOTOR_COUNT];
    logic signed [VAL_W-1:0] last_reg [MOTOR_COUNT];
    logic signed [VAL_W-1:0] last_next [MOTOR_COUNT];
    logic signed [SUM_W-1:0] sum_reg [MOTOR_COUNT];
    logic signed [SUM_W-1:0] sum_next [MOTOR_COUNT];
    logic signed [VAL_W-1:0] cmd_reg [MOTOR_COUNT];
    logic signed [VAL_W-1:0] cmd_next [MOTOR_COUNT];

    logic       origin_taken_reg, origin_taken_next;
    logic [7:0] seen_reg, seen_next;
    logic       ready_reg, ready_next;
    logic       setup_done_reg, setup_done_next;
    ctl_state_t state_reg, state_next;
    term_t      term_reg, term_next;
    logic [1:0] m_reg, m_next;
    logic       bilat_reg, bilat_next;
    logic signed [SUM_W-1:0] tgt_reg, tgt_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] v_reg, v_next;
    logic                    out_valid_reg, out_valid_next;
    logic [4*VAL_W-1:0]      out_data_reg, out_data_next;
    logic                    out_phase_reg, out_phase_next;

    logic                     mul_start;
    logic signed [GAIN_W-1:0] mul_gain;
    logic signed [MUL_XW-1:0] mul_x;
    logic                     mul_done;
    logic signed [PROD_W-1:0] mul_prod;
    logic signed [PROD_W-1:0] prod_fl;

    logic signed [VAL_W-1:0] tm, pm, om;
    logic signed [SUM_W:0]   diff_e;
    logic signed [SUM_W-1:0] e_val, sum_new;
    logic signed [VAL_W:0]   d_val;
    logic [1:0]              opp_idx, mst_idx;
    logic signed [VAL_W+1:0] disp_raw, disp;
    logic signed [ACC_W-1:0] base, vt;
    logic signed [SUM_W-1:0] trunc_v;
    logic signed [VAL_W+3:0] m4, m6, t5;
    logic                    win_all;

    bttp_mul #(
        .GW (GAIN_W),
        .XW (MUL_XW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .gain    (mul_gain),
        .operand (mul_x),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            kp_reg     <= '0;
            ki_reg     <= '0;
            kd_reg     <= '0;
            fg_reg     <= GAIN_W'(65536);
            fr_reg     <= GAIN_W'(65536);
            margin_reg <= '0;
            dir_reg    <= '0;
            warm_reg   <= 8'd1;
        end
        else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_PROP:   kp_reg     <= cfg_data[GAIN_W-1:0];
                REG_INTEG:  ki_reg     <= cfg_data[GAIN_W-1:0];
                REG_DERIV:  kd_reg     <= cfg_data[GAIN_W-1:0];
                REG_FOLLOW: fg_reg     <= cfg_data[GAIN_W-1:0];
                REG_RATIO:  fr_reg     <= cfg_data[GAIN_W-1:0];
                REG_MARGIN: margin_reg <= cfg_data[VAL_W-1:0];
                REG_DIR:    dir_reg    <= cfg_data[MOTOR_COUNT-1:0];
                REG_WARMUP: warm_reg   <= cfg_data[7:0];
                default:    kp_reg     <= kp_reg;
            endcase
        end
    end

    always_comb
    begin
        tm      = ten_reg[m_reg];
        pm      = pos_reg[m_reg];
        om      = origin_reg[m_reg];
        diff_e  = {tgt_reg[SUM_W-1], tgt_reg} - (SUM_W+1)'(tm);
        e_val   = sat48(diff_e);
        sum_new = sat48({sum_reg[m_reg][SUM_W-1], sum_reg[m_reg]} + {e_val[SUM_W-1], e_val});
        d_val   = (VAL_W+1)'(tm) - (VAL_W+1)'(last_reg[m_reg]);
        opp_idx = {~m_reg[1], 1'b1};
        mst_idx = {m_reg[1], 1'b0};
        disp_raw = (VAL_W+2)'(pos_reg[mst_idx]) - (VAL_W+2)'(origin_reg[mst_idx]);
        disp     = dir_reg[mst_idx] ? -disp_raw : disp_raw;
        prod_fl  = mul_prod >>> FRAC_W;
        base     = (term_reg == TERM_FOLLOW) ? ACC_W'(om) : ACC_W'(pm);
        vt       = (v_reg < 0) ? ((v_reg + ACC_W'(65535)) >>> FRAC_W) : (v_reg >>> FRAC_W);
        trunc_v  = vt[SUM_W-1:0];
        m4       = (VAL_W+4)'(margin_reg) <<< 2;
        m6       = ((VAL_W+4)'(margin_reg) <<< 2) + ((VAL_W+4)'(margin_reg) <<< 1);
        win_all  = 1'b1;
        for (int i = 0; i < MOTOR_COUNT; i++) begin
            t5 = ((VAL_W+4)'(ten_reg[i]) <<< 2) + (VAL_W+4)'(ten_reg[i]);
            if (!(m4 < t5 && t5 < m6)) begin
                win_all = 1'b0;
            end
        end
    end

    always_comb
    begin
        pos_next          = pos_reg;
        origin_next       = origin_reg;
        ten_next          = ten_reg;
        last_next         = last_reg;
        sum_next          = sum_reg;
        cmd_next          = cmd_reg;
        origin_taken_next = origin_taken_reg;
        seen_next         = seen_reg;
        ready_next        = ready_reg;
        setup_done_next   = setup_done_reg;
        state_next        = state_reg;
        term_next         = term_reg;
        m_next            = m_reg;
        bilat_next        = bilat_reg;
        tgt_next          = tgt_reg;
        acc_next          = acc_reg;
        v_next            = v_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_data_next     = out_data_reg;
        out_phase_next    = out_phase_reg;
        mul_start         = 1'b0;
        mul_gain          = kp_reg;
        mul_x             = MUL_XW'(e_val);

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid) begin
                    if (s_tuser[0]) begin
                        for (int i = 0; i < MOTOR_COUNT; i++) begin
                            pos_next[i] = s_tdata[VAL_W*i +: VAL_W];
                            if (!origin_taken_reg) begin
                                origin_next[i] = s_tdata[VAL_W*i +: VAL_W];
                            end
                        end
                        origin_taken_next = 1'b1;
                    end
                    if (s_tuser[1]) begin
                        for (int i = 0; i < MOTOR_COUNT; i++) begin
                            last_next[i] = ten_reg[i];
                            ten_next[i]  = s_tdata[VAL_W*(MOTOR_COUNT+i) +: VAL_W];
                        end
                        if (!ready_reg) begin
                            if (seen_reg != 8'hFF) begin
                                seen_next = seen_reg + 1'b1;
                            end
                            if (seen_next >= warm_reg) begin
                                ready_next = 1'b1;
                            end
                        end
                    end
                    if (origin_taken_next && ready_next) begin
                        bilat_next = setup_done_reg;
                        m_next     = '0;
                        state_next = ST_START;
                    end
                    else begin
                        setup_done_next = 1'b1;
                    end
                end
            end
            ST_START:
            begin
                if (bilat_reg && m_reg[0]) begin
                    mul_start  = 1'b1;
                    mul_gain   = fg_reg;
                    mul_x      = MUL_XW'(disp);
                    term_next  = TERM_FOLLOW;
                    state_next = ST_MUL;
                end
                else if (bilat_reg) begin
                    mul_start  = 1'b1;
                    mul_gain   = fr_reg;
                    mul_x      = MUL_XW'(ten_reg[opp_idx]);
                    term_next  = TERM_TGT;
                    state_next = ST_MUL;
                end
                else begin
                    tgt_next   = SUM_W'(margin_reg);
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                sum_next[m_reg] = sum_new;
                mul_start       = 1'b1;
                mul_gain        = kp_reg;
                mul_x           = MUL_XW'(e_val);
                term_next       = TERM_P;
                state_next      = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_done) begin
                    state_next = ST_POST;
                end
            end
            ST_POST:
            begin
                case (term_reg)
                    TERM_TGT:
                    begin
                        tgt_next   = prod_fl[SUM_W-1:0] + SUM_W'(margin_reg);
                        state_next = ST_ERR;
                    end
                    TERM_P:
                    begin
                        acc_next   = prod_fl[ACC_W-1:0];
                        mul_start  = 1'b1;
                        mul_gain   = kd_reg;
                        mul_x      = MUL_XW'(d_val);
                        term_next  = TERM_D;
                        state_next = ST_MUL;
                    end
                    TERM_D:
                    begin
                        acc_next   = acc_reg + prod_fl[ACC_W-1:0];
                        mul_start  = 1'b1;
                        mul_gain   = ki_reg;
                        mul_x      = MUL_XW'(sum_reg[m_reg]);
                        term_next  = TERM_I;
                        state_next = ST_MUL;
                    end
                    TERM_I:
                    begin
                        acc_next   = acc_reg + prod_fl[ACC_W-1:0];
                        state_next = ST_CMD;
                    end
                    TERM_FOLLOW:
                    begin
                        acc_next   = mul_prod[ACC_W-1:0];
                        state_next = ST_CMD;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_CMD:
            begin
                v_next     = (dir_reg[m_reg] ? -acc_reg : acc_reg) + (base <<< FRAC_W);
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                cmd_next[m_reg] = sat32(trunc_v);
                if (m_reg == 2'd3) begin
                    state_next = ST_DONE;
                end
                else begin
                    m_next     = m_reg + 1'b1;
                    state_next = ST_START;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {cmd_reg[3], cmd_reg[2], cmd_reg[1], cmd_reg[0]};
                    out_phase_next = bilat_reg;
                    if (!bilat_reg && win_all) begin
                        sum_next[0]     = '0;
                        sum_next[2]     = '0;
                        setup_done_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= ST_IDLE;
            term_reg         <= TERM_TGT;
            m_reg            <= '0;
            bilat_reg        <= 1'b0;
            origin_taken_reg <= 1'b0;
            seen_reg         <= '0;
            ready_reg        <= 1'b0;
            setup_done_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                pos_reg[i]  <= '0;
                ten_reg[i]  <= '0;
                last_reg[i] <= '0;
                sum_reg[i]  <= '0;
            end
        end
        else begin
            state_reg        <= state_next;
            term_reg         <= term_next;
            m_reg            <= m_next;
            bilat_reg        <= bilat_next;
            origin_taken_reg <= origin_taken_next;
            seen_reg         <= seen_next;
            ready_reg        <= ready_next;
            setup_done_reg   <= setup_done_next;
            out_valid_reg    <= out_valid_next;
            pos_reg          <= pos_next;
            ten_reg          <= ten_next;
            last_reg         <= last_next;
            sum_reg          <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        origin_reg    <= origin_next;
        cmd_reg       <= cmd_next;
        tgt_reg       <= tgt_next;
        acc_reg       <= acc_next;
        v_reg         <= v_next;
        out_data_reg  <= out_data_next;
        out_phase_reg <= out_phase_next;
    end

endmodule
